@@ rtl/lpfd_pkg.sv @@
// Package for the length-framed packet deframer.
// Field widths, register indexes, frame phase codes and the chain control struct.
// No dependencies.
package lpfd_pkg;

   localparam int MAX_DATA_DEF = 32;
   localparam int STORE_DEPTH  = 32;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 6;
   localparam int IDX_W   = 5;
   localparam int CSR_A_W = 3;

   localparam logic [BYTE_W-1:0] SECOND_MASK = 8'hFE;

   localparam logic [CSR_A_W-1:0] REG_FIRST_START  = 3'd0;
   localparam logic [CSR_A_W-1:0] REG_SECOND_START = 3'd1;
   localparam logic [CSR_A_W-1:0] REG_TRAILER      = 3'd2;
   localparam logic [CSR_A_W-1:0] REG_CONFIRM_EN   = 3'd3;
   localparam logic [CSR_A_W-1:0] REG_OK_TYPE      = 3'd4;

   localparam logic [BYTE_W-1:0] FIRST_START_RST  = 8'd85;
   localparam logic [BYTE_W-1:0] SECOND_START_RST = 8'd170;
   localparam logic [BYTE_W-1:0] TRAILER_RST      = 8'd69;
   localparam logic              CONFIRM_EN_RST   = 1'b1;
   localparam logic [BYTE_W-1:0] OK_TYPE_RST      = 8'd0;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_CONFIRM = 1'b1;

   localparam int PH_W = 3;
   localparam logic [PH_W-1:0] PH_IDLE    = 3'd0;
   localparam logic [PH_W-1:0] PH_SECOND  = 3'd1;
   localparam logic [PH_W-1:0] PH_TYPE    = 3'd2;
   localparam logic [PH_W-1:0] PH_LENGTH  = 3'd3;
   localparam logic [PH_W-1:0] PH_DATA    = 3'd4;
   localparam logic [PH_W-1:0] PH_TRAILER = 3'd5;
   localparam logic [PH_W-1:0] PH_ALIGN   = 3'd6;
   localparam logic [PH_W-1:0] PH_EMIT    = 3'd7;

   typedef struct packed {
      logic shift;
      logic load;
   } chain_ctl_type;

endpackage

@@ rtl/lpfd_if.sv @@
// Handshake channels of the length-framed packet deframer: request, response, csr.
// Depends on lpfd_pkg.
interface lpfd_req_if;
   logic                       valid;
   logic                       ready;
   logic [lpfd_pkg::BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [lpfd_pkg::BYTE_W-1:0] packet_type;
   logic [lpfd_pkg::LEN_W-1:0]  payload_length;
   logic                        ack_requested;
   logic [lpfd_pkg::IDX_W-1:0]  byte_index;
   logic [lpfd_pkg::BYTE_W-1:0] data_byte;
   logic                        last;
   modport source (output valid, output kind, output packet_type, output payload_length,
                   output ack_requested, output byte_index, output data_byte,
                   output last, input ready);
   modport sink   (input valid, input kind, input packet_type, input payload_length,
                   input ack_requested, input byte_index, input data_byte,
                   input last, output ready);
endinterface

interface lpfd_csr_if;
   logic                         valid;
   logic                         ready;
   logic [lpfd_pkg::CSR_A_W-1:0] index;
   logic [lpfd_pkg::BYTE_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/lpfd_cell.sv @@
// One payload byte cell of the store chain; loads its neighbor's byte on shift.
// Depends on lpfd_pkg.
module lpfd_cell (
   input  logic                        clock,
   input  logic                        shift,
   input  logic [lpfd_pkg::BYTE_W-1:0] din,
   output logic [lpfd_pkg::BYTE_W-1:0] dout
);
   import lpfd_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   assign byte_in = shift ? din : byte_ff;
   assign dout    = byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end
endmodule

@@ rtl/lpfd_chain.sv @@
// Row of payload cells. Bytes enter at the tail and move toward the head;
// when not loading, the head byte wraps to the tail. Depends on lpfd_pkg, lpfd_cell.
module lpfd_chain #(
   parameter int DEPTH = lpfd_pkg::STORE_DEPTH
) (
   input  logic                        clock,
   input  lpfd_pkg::chain_ctl_type     ctl,
   input  logic [lpfd_pkg::BYTE_W-1:0] rx_byte,
   output logic [lpfd_pkg::BYTE_W-1:0] head
);
   import lpfd_pkg::*;

   logic [BYTE_W-1:0] link [DEPTH+1];

   assign link[DEPTH] = ctl.load ? rx_byte : link[0];
   assign head        = link[0];

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      lpfd_cell u_cell (
         .clock (clock),
         .shift (ctl.shift),
         .din   (link[k+1]),
         .dout  (link[k])
      );
   end
endmodule

@@ rtl/length_framed_packet_deframer.sv @@
// Top level of the length-framed packet deframer: frame sequencer, csr bank, cell chain.
// Depends on lpfd_pkg, lpfd_if, lpfd_chain.
//
//   channel  dir  payload                                          beat taken when
//   req_ch   in   rx_byte                                          valid && ready
//   rsp_ch   out  kind, packet_type, payload_length, ack_requested,  valid && ready
//                 byte_index, data_byte, last
//   csr_ch   in   index, data                                      valid (ready tied high)
//
// Header, data and trailer bytes are each taken on a req_ch beat. After a good trailer
// on a data packet the chain rotates by min(MAX_DATA, STORE_DEPTH) - length positions
// to bring byte 0 to its head (an empty or OK packet skips that), then gives one beat
// per cycle while rsp_ch.ready is high; req_ch.ready is low during that readout.
// Synchronous reset returns the sequencer to hunting and the csr bank to defaults;
// the chain cells are not reset.
module length_framed_packet_deframer #(
   parameter int MAX_DATA = lpfd_pkg::MAX_DATA_DEF
) (
   input logic        clock,
   input logic        reset,
   lpfd_req_if.sink   req_ch,
   lpfd_rsp_if.source rsp_ch,
   lpfd_csr_if.sink   csr_ch
);
   import lpfd_pkg::*;

   localparam int LIMIT = (MAX_DATA < STORE_DEPTH) ? MAX_DATA : STORE_DEPTH;
   localparam int CW    = $clog2(LIMIT + 1);
   localparam logic [BYTE_W-1:0] LIMIT_B = BYTE_W'(LIMIT);
   localparam logic [CW-1:0]     LIMIT_C = CW'(LIMIT);

   logic [BYTE_W-1:0] first_ff, first_in;
   logic [BYTE_W-1:0] second_ff, second_in;
   logic [BYTE_W-1:0] trailer_ff, trailer_in;
   logic              confirm_ff, confirm_in;
   logic [BYTE_W-1:0] ok_type_ff, ok_type_in;

   logic [PH_W-1:0]   phase_ff, phase_in;
   logic [BYTE_W-1:0] hdr2_ff, hdr2_in;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CW-1:0]     rcv_ff, rcv_in;
   logic [CW-1:0]     align_ff, align_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              single_ff, single_in;
   logic              kind_ff, kind_in;

   logic              req_beat, rsp_beat, csr_beat;
   logic [CW-1:0]     rcv_next;
   logic [BYTE_W-1:0] rx;
   logic [BYTE_W-1:0] head;
   logic              last_beat;
   chain_ctl_type     ctl;

   assign rx       = req_ch.rx_byte;
   assign req_beat = req_ch.valid && req_ch.ready;
   assign rsp_beat = rsp_ch.valid && rsp_ch.ready;
   assign csr_beat = csr_ch.valid && csr_ch.ready;
   assign rcv_next = rcv_ff + CW'(1);

   assign req_ch.ready = (phase_ff != PH_ALIGN) && (phase_ff != PH_EMIT);
   assign csr_ch.ready = 1'b1;

   assign last_beat = single_ff || ((LEN_W'(idx_ff) + LEN_W'(1)) == len_ff);

   assign rsp_ch.valid          = (phase_ff == PH_EMIT);
   assign rsp_ch.kind           = kind_ff;
   assign rsp_ch.packet_type    = type_ff;
   assign rsp_ch.payload_length = len_ff;
   assign rsp_ch.ack_requested  = hdr2_ff[0];
   assign rsp_ch.byte_index     = single_ff ? '0 : idx_ff;
   assign rsp_ch.data_byte      = single_ff ? '0 : head;
   assign rsp_ch.last           = last_beat;

   // csr bank
   always_comb begin
      first_in   = first_ff;
      second_in  = second_ff;
      trailer_in = trailer_ff;
      confirm_in = confirm_ff;
      ok_type_in = ok_type_ff;
      if (csr_beat) begin
         case (csr_ch.index)
            REG_FIRST_START:  first_in   = csr_ch.data;
            REG_SECOND_START: second_in  = csr_ch.data;
            REG_TRAILER:      trailer_in = csr_ch.data;
            REG_CONFIRM_EN:   confirm_in = csr_ch.data[0];
            REG_OK_TYPE:      ok_type_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   // frame sequencer
   always_comb begin
      phase_in  = phase_ff;
      hdr2_in   = hdr2_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      rcv_in    = rcv_ff;
      align_in  = align_ff;
      idx_in    = idx_ff;
      single_in = single_ff;
      kind_in   = kind_ff;
      ctl.shift = 1'b0;
      ctl.load  = 1'b0;
      case (phase_ff)
         PH_SECOND: begin
            if (req_beat) begin
               hdr2_in  = rx;
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if (req_beat) begin
               type_in  = rx;
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            if (req_beat) begin
               len_in = rx[LEN_W-1:0];
               rcv_in = '0;
               if (((hdr2_ff & SECOND_MASK) != second_ff) || (rx > LIMIT_B)) begin
                  phase_in = PH_IDLE;
               end else if (rx == '0) begin
                  phase_in = PH_TRAILER;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (req_beat) begin
               ctl.shift = 1'b1;
               ctl.load  = 1'b1;
               rcv_in    = rcv_next;
               if (LEN_W'(rcv_next) >= len_ff) begin
                  phase_in = PH_TRAILER;
               end
            end
         end
         PH_TRAILER: begin
            if (req_beat) begin
               phase_in = PH_IDLE;
               idx_in   = '0;
               if (rx == trailer_ff) begin
                  if (confirm_ff && (type_ff == ok_type_ff)) begin
                     kind_in   = KIND_CONFIRM;
                     single_in = 1'b1;
                     phase_in  = PH_EMIT;
                  end else if (len_ff == '0) begin
                     kind_in   = KIND_PAYLOAD;
                     single_in = 1'b1;
                     phase_in  = PH_EMIT;
                  end else begin
                     kind_in   = KIND_PAYLOAD;
                     single_in = 1'b0;
                     align_in  = LIMIT_C - len_ff[CW-1:0];
                     phase_in  = (LIMIT_C == len_ff[CW-1:0]) ? PH_EMIT : PH_ALIGN;
                  end
               end
            end
         end
         PH_ALIGN: begin
            ctl.shift = 1'b1;
            align_in  = align_ff - CW'(1);
            if (align_ff == CW'(1)) begin
               phase_in = PH_EMIT;
            end
         end
         PH_EMIT: begin
            if (rsp_beat) begin
               if (last_beat) begin
                  phase_in = PH_IDLE;
               end else begin
                  ctl.shift = 1'b1;
                  idx_in    = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            if (req_beat) begin
               phase_in = (rx == first_ff) ? PH_SECOND : PH_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= FIRST_START_RST;
         second_ff  <= SECOND_START_RST;
         trailer_ff <= TRAILER_RST;
         confirm_ff <= CONFIRM_EN_RST;
         ok_type_ff <= OK_TYPE_RST;
         phase_ff   <= PH_IDLE;
         hdr2_ff    <= '0;
         type_ff    <= '0;
         len_ff     <= '0;
         rcv_ff     <= '0;
      end else begin
         first_ff   <= first_in;
         second_ff  <= second_in;
         trailer_ff <= trailer_in;
         confirm_ff <= confirm_in;
         ok_type_ff <= ok_type_in;
         phase_ff   <= phase_in;
         hdr2_ff    <= hdr2_in;
         type_ff    <= type_in;
         len_ff     <= len_in;
         rcv_ff     <= rcv_in;
      end
   end

   always_ff @(posedge clock) begin
      align_ff  <= align_in;
      idx_ff    <= idx_in;
      single_ff <= single_in;
      kind_ff   <= kind_in;
   end

   lpfd_chain #(
      .DEPTH (LIMIT)
   ) u_chain (
      .clock   (clock),
      .ctl     (ctl),
      .rx_byte (rx),
      .head    (head)
   );
endmodule
